// ----- sv/frame_filter_rssi_table_top_macros.svh -----
// ----------------------------------------------------------------------------
// frame filter rssi table assertion macros
// concurrent assertion helpers used by the top level rtl file of the block
// ----------------------------------------------------------------------------
`ifndef FRAME_FILTER_RSSI_TABLE_TOP_MACROS_SVH
`define FRAME_FILTER_RSSI_TABLE_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define FFRT_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ffrt assertion failed");

// next-cycle implication
`define FFRT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ffrt assertion failed");

`else

`define FFRT_ASSERT_IMPL(label, clk, rst, ante, cons)
`define FFRT_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- sv/ffrt_pkg.sv -----
// ----------------------------------------------------------------------------
// ffrt_pkg
// shared constants and types of the frame filter and strength table
// ----------------------------------------------------------------------------
package ffrt_pkg;

   // defaults of the top level parameters
   localparam int ENTRIES_DEF       = 16;
   localparam int MIN_FRAME_LEN_DEF = 32;
   localparam int QUEUE_DEPTH_DEF   = 2;

   // field widths
   localparam int LEN_W  = 12;
   localparam int BYTE_W = 8;
   localparam int ORG_W  = 24;
   localparam int MAC_W  = 48;
   localparam int RSSI_W = 8;
   localparam int ENTRY_W = MAC_W + RSSI_W;

   // opcodes
   localparam logic OP_OBSERVE = 1'b0;
   localparam logic OP_LOOKUP  = 1'b1;

   // vendor signature
   localparam logic [BYTE_W-1:0] CAT_VENDOR  = 8'd127;
   localparam logic [BYTE_W-1:0] ELEM_VENDOR = 8'd221;
   localparam logic [BYTE_W-1:0] VENDOR_TYPE = 8'd4;
   localparam logic [ORG_W-1:0]  VENDOR_OUI  = 24'h18FE34;

   // classified command between front and back
   typedef struct packed {
      logic                     lookup;
      logic                     pass;
      logic [MAC_W-1:0]         mac;
      logic signed [RSSI_W-1:0] rssi;
   } cmd_type;

   typedef enum logic {
      BACK_IDLE,
      BACK_SEARCH
   } back_state_type;

endpackage

// ----- sv/ffrt_ram.sv -----
// ----------------------------------------------------------------------------
// ffrt_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module ffrt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/ffrt_front.sv -----
// ----------------------------------------------------------------------------
// ffrt_front
// request intake: checks the vendor signature and builds one command
// ----------------------------------------------------------------------------
module ffrt_front #(
   parameter int MIN_FRAME_LEN = ffrt_pkg::MIN_FRAME_LEN_DEF
) (
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_op,
   input  logic [ffrt_pkg::LEN_W-1:0]            req_frame_len,
   input  logic [ffrt_pkg::BYTE_W-1:0]           req_category_code,
   input  logic [ffrt_pkg::ORG_W-1:0]            req_header_org,
   input  logic [ffrt_pkg::BYTE_W-1:0]           req_element_id,
   input  logic [ffrt_pkg::ORG_W-1:0]            req_element_org,
   input  logic [ffrt_pkg::BYTE_W-1:0]           req_element_type,
   input  logic [ffrt_pkg::MAC_W-1:0]            req_src_mac,
   input  logic signed [ffrt_pkg::RSSI_W-1:0]    req_signal_dbm,
   input  logic [ffrt_pkg::MAC_W-1:0]            req_query_mac,
   input  logic                                  q_ready,
   output logic                                  q_push,
   output ffrt_pkg::cmd_type                     q_cmd
);

   logic sig_ok;

   assign sig_ok = (req_frame_len >= ffrt_pkg::LEN_W'(MIN_FRAME_LEN))
                && (req_category_code == ffrt_pkg::CAT_VENDOR)
                && (req_header_org == ffrt_pkg::VENDOR_OUI)
                && (req_element_id == ffrt_pkg::ELEM_VENDOR)
                && (req_element_org == ffrt_pkg::VENDOR_OUI)
                && (req_element_type == ffrt_pkg::VENDOR_TYPE);

   assign req_ready = q_ready;
   assign q_push    = req_valid && q_ready;

   always_comb begin
      q_cmd.lookup = (req_op == ffrt_pkg::OP_LOOKUP);
      q_cmd.pass   = (req_op == ffrt_pkg::OP_OBSERVE) && sig_ok;
      q_cmd.mac    = (req_op == ffrt_pkg::OP_LOOKUP) ? req_query_mac : req_src_mac;
      q_cmd.rssi   = req_signal_dbm;
   end

endmodule

// ----- sv/ffrt_queue.sv -----
// ----------------------------------------------------------------------------
// ffrt_queue
// short command fifo between intake and execution
// ----------------------------------------------------------------------------
module ffrt_queue #(
   parameter int DEPTH = ffrt_pkg::QUEUE_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ffrt_pkg::cmd_type push_cmd,
   output logic              not_full,
   input  logic              pop,
   output logic              not_empty,
   output ffrt_pkg::cmd_type pop_cmd
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   ffrt_pkg::cmd_type mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign not_full  = (count_ff != FULL_CNT);
   assign not_empty = (count_ff != '0);
   assign do_push   = push && not_full;
   assign do_pop    = pop && not_empty;
   assign pop_cmd   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ----- sv/ffrt_back.sv -----
// ----------------------------------------------------------------------------
// ffrt_back
// command execution: ring writes, newest-first search, result register
// ----------------------------------------------------------------------------
module ffrt_back #(
   parameter int ENTRIES = ffrt_pkg::ENTRIES_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               q_valid,
   input  ffrt_pkg::cmd_type                  q_cmd,
   output logic                               q_pop,
   output logic                               busy,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_accepted,
   output logic                               rsp_hit,
   output logic signed [ffrt_pkg::RSSI_W-1:0] rsp_rssi_out
);

   localparam int IDX_W = $clog2(ENTRIES);
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(ENTRIES);

   ffrt_pkg::back_state_type state_ff, state_in;

   logic [IDX_W-1:0] write_slot_ff;
   logic [CNT_W-1:0] fill_ff;
   logic [IDX_W-1:0] addr_ff;
   logic [CNT_W-1:0] remain_ff;
   logic             rd_valid_ff;
   logic             rd_last_ff;
   logic [ffrt_pkg::MAC_W-1:0] query_ff;

   logic rsp_valid_ff;
   logic rsp_accepted_ff;
   logic rsp_hit_ff;
   logic signed [ffrt_pkg::RSSI_W-1:0] rsp_rssi_ff;

   logic out_free, start, found, exhausted;
   logic ram_we, ram_re;
   logic [ffrt_pkg::ENTRY_W-1:0] ram_wdata, ram_rdata;
   logic load, load_accepted, load_hit;
   logic signed [ffrt_pkg::RSSI_W-1:0] load_rssi;

   function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] a);
      return (a == '0) ? LAST_IDX : a - 1'b1;
   endfunction

   function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] a);
      return (a == LAST_IDX) ? '0 : a + 1'b1;
   endfunction

   ffrt_ram #(
      .WIDTH (ffrt_pkg::ENTRY_W),
      .DEPTH (ENTRIES)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (write_slot_ff),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (addr_ff),
      .rd_data (ram_rdata)
   );

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign start     = (state_ff == ffrt_pkg::BACK_IDLE) && q_valid && out_free;
   assign found     = rd_valid_ff
                   && (ram_rdata[ffrt_pkg::ENTRY_W-1:ffrt_pkg::RSSI_W] == query_ff);
   assign exhausted = rd_valid_ff && rd_last_ff;
   assign ram_wdata = {q_cmd.mac, q_cmd.rssi};

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ffrt_pkg::BACK_IDLE: begin
            if (start && q_cmd.lookup && (fill_ff != '0)) begin
               state_in = ffrt_pkg::BACK_SEARCH;
            end
         end
         ffrt_pkg::BACK_SEARCH: begin
            if (found || exhausted) begin
               state_in = ffrt_pkg::BACK_IDLE;
            end
         end
         default: state_in = ffrt_pkg::BACK_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      q_pop         = 1'b0;
      ram_we        = 1'b0;
      ram_re        = 1'b0;
      load          = 1'b0;
      load_accepted = 1'b0;
      load_hit      = 1'b0;
      load_rssi     = '0;
      unique case (state_ff)
         ffrt_pkg::BACK_IDLE: begin
            q_pop         = start;
            ram_we        = start && !q_cmd.lookup && q_cmd.pass;
            load          = start && (!q_cmd.lookup || (fill_ff == '0));
            load_accepted = !q_cmd.lookup && q_cmd.pass;
         end
         ffrt_pkg::BACK_SEARCH: begin
            ram_re   = (remain_ff != '0);
            load     = found || exhausted;
            load_hit = found;
            if (found) begin
               load_rssi = signed'(ram_rdata[ffrt_pkg::RSSI_W-1:0]);
            end
         end
         default: begin
            q_pop = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ffrt_pkg::BACK_IDLE;
         write_slot_ff <= '0;
         fill_ff       <= '0;
         remain_ff     <= '0;
         rd_valid_ff   <= 1'b0;
         rd_last_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         rd_valid_ff <= ram_re;
         rd_last_ff  <= ram_re && (remain_ff == CNT_W'(1));
         if (ram_we) begin
            write_slot_ff <= idx_inc(write_slot_ff);
            if (fill_ff != FULL_CNT) begin
               fill_ff <= fill_ff + 1'b1;
            end
         end
         if (start) begin
            remain_ff <= fill_ff;
         end else if (ram_re) begin
            remain_ff <= remain_ff - 1'b1;
         end
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         query_ff <= q_cmd.mac;
         addr_ff  <= idx_dec(write_slot_ff);
      end else if (ram_re) begin
         addr_ff  <= idx_dec(addr_ff);
      end
      if (load) begin
         rsp_accepted_ff <= load_accepted;
         rsp_hit_ff      <= load_hit;
         rsp_rssi_ff     <= load_rssi;
      end
   end

   assign busy         = (state_ff == ffrt_pkg::BACK_SEARCH);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_accepted = rsp_accepted_ff;
   assign rsp_hit      = rsp_hit_ff;
   assign rsp_rssi_out = rsp_rssi_ff;

endmodule

// ----- sv/frame_filter_rssi_table_top.sv -----
// ----------------------------------------------------------------------------
// frame_filter_rssi_table_top
// vendor frame filter with a ring of recent source addresses and strengths
// ----------------------------------------------------------------------------
// usage
//   req_ channel: one transfer per operation. op observe checks the header
//   fields against the vendor signature and, on a pass, stores src_mac and
//   signal_dbm in the ring (oldest slot overwritten when full). op lookup
//   searches the held entries newest first for query_mac.
//   rsp_ channel: exactly one transfer per request, in request order.
//   accepted for observe, hit and rssi_out for lookup, the rest zero.
// throughput and search
//   observe: result through the command queue and the result register, one
//   per cycle sustained while rsp_ready stays high. lookup: the search
//   walks the held entries newest first up to the newest match, all held
//   entries on a miss; the single read port of the ring memory steps one
//   entry per cycle, and the back end takes no other command meanwhile.
//   an empty ring answers a lookup like an observe.
// reset and stall
//   reset empties the ring and the command queue; no clearing pass. a
//   stalled rsp_ready holds the result and the back end, requests keep
//   being taken until the command queue is full.
// ----------------------------------------------------------------------------
`include "frame_filter_rssi_table_top_macros.svh"

module frame_filter_rssi_table_top #(
   parameter int ENTRIES       = ffrt_pkg::ENTRIES_DEF,
   parameter int MIN_FRAME_LEN = ffrt_pkg::MIN_FRAME_LEN_DEF,
   parameter int QUEUE_DEPTH   = ffrt_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_op,
   input  logic [ffrt_pkg::LEN_W-1:0]         req_frame_len,
   input  logic [ffrt_pkg::BYTE_W-1:0]        req_category_code,
   input  logic [ffrt_pkg::ORG_W-1:0]         req_header_org,
   input  logic [ffrt_pkg::BYTE_W-1:0]        req_element_id,
   input  logic [ffrt_pkg::ORG_W-1:0]         req_element_org,
   input  logic [ffrt_pkg::BYTE_W-1:0]        req_element_type,
   input  logic [ffrt_pkg::MAC_W-1:0]         req_src_mac,
   input  logic signed [ffrt_pkg::RSSI_W-1:0] req_signal_dbm,
   input  logic [ffrt_pkg::MAC_W-1:0]         req_query_mac,
   // response channel
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_accepted,
   output logic                               rsp_hit,
   output logic signed [ffrt_pkg::RSSI_W-1:0] rsp_rssi_out
);

   // classified command path
   ffrt_pkg::cmd_type push_cmd;
   ffrt_pkg::cmd_type pop_cmd;
   logic              q_push;
   logic              q_not_full;
   logic              q_not_empty;
   logic              q_pop;
   logic              back_busy;

   // intake and signature check
   ffrt_front #(
      .MIN_FRAME_LEN (MIN_FRAME_LEN)
   ) u_front (
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_op            (req_op),
      .req_frame_len     (req_frame_len),
      .req_category_code (req_category_code),
      .req_header_org    (req_header_org),
      .req_element_id    (req_element_id),
      .req_element_org   (req_element_org),
      .req_element_type  (req_element_type),
      .req_src_mac       (req_src_mac),
      .req_signal_dbm    (req_signal_dbm),
      .req_query_mac     (req_query_mac),
      .q_ready           (q_not_full),
      .q_push            (q_push),
      .q_cmd             (push_cmd)
   );

   // decouples intake from a long search
   ffrt_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_cmd  (push_cmd),
      .not_full  (q_not_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .pop_cmd   (pop_cmd)
   );

   // ring memory, search sequencer and result register
   ffrt_back #(
      .ENTRIES (ENTRIES)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (q_not_empty),
      .q_cmd        (pop_cmd),
      .q_pop        (q_pop),
      .busy         (back_busy),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_accepted (rsp_accepted),
      .rsp_hit      (rsp_hit),
      .rsp_rssi_out (rsp_rssi_out)
   );

   // an observe result never carries lookup fields
   `FFRT_ASSERT_IMPL(a_observe_clean, clock, reset,
      rsp_valid && rsp_accepted, !rsp_hit && (rsp_rssi_out == 8'sd0))

   // a miss reports zero strength
   `FFRT_ASSERT_IMPL(a_miss_zero, clock, reset,
      rsp_valid && !rsp_hit, rsp_rssi_out == 8'sd0)

   // every popped command either answers at once or starts a search
   `FFRT_ASSERT_NEXT(a_pop_progress, clock, reset,
      q_pop, rsp_valid || back_busy)

endmodule

// ----- dv/frame_filter_rssi_table_check.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// frame_filter_rssi_table_check
// watches the request and response transfers of the frame filter, keeps its
// own copy of the strength ring, and compares every response in order
// ----------------------------------------------------------------------------
module frame_filter_rssi_table_check
   import ffrt_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_ready,
   input  logic                     req_op,
   input  logic [LEN_W-1:0]         req_frame_len,
   input  logic [BYTE_W-1:0]        req_category_code,
   input  logic [ORG_W-1:0]         req_header_org,
   input  logic [BYTE_W-1:0]        req_element_id,
   input  logic [ORG_W-1:0]         req_element_org,
   input  logic [BYTE_W-1:0]        req_element_type,
   input  logic [MAC_W-1:0]         req_src_mac,
   input  logic signed [RSSI_W-1:0] req_signal_dbm,
   input  logic [MAC_W-1:0]         req_query_mac,
   input  logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  logic                     rsp_accepted,
   input  logic                     rsp_hit,
   input  logic signed [RSSI_W-1:0] rsp_rssi_out,
   output int                       failures,
   output int                       outstanding
);

   localparam int RING_SLOTS = ENTRIES_DEF;
   localparam int MIN_LEN    = MIN_FRAME_LEN_DEF;

   typedef struct {
      logic                     accepted;
      logic                     hit;
      logic signed [RSSI_W-1:0] rssi;
   } table_reply_t;

   logic [MAC_W-1:0]         ring_mac  [RING_SLOTS];
   logic signed [RSSI_W-1:0] ring_rssi [RING_SLOTS];
   int                       next_slot;
   int                       held;
   int                       reply_count;
   table_reply_t             reply_queue [$];

   function automatic logic vendor_frame_ok(
      logic [LEN_W-1:0] len, logic [BYTE_W-1:0] cat, logic [ORG_W-1:0] horg,
      logic [BYTE_W-1:0] eid, logic [ORG_W-1:0] eorg, logic [BYTE_W-1:0] etype);
      return (len >= LEN_W'(MIN_LEN)) && (cat == CAT_VENDOR) && (horg == VENDOR_OUI)
         && (eid == ELEM_VENDOR) && (eorg == VENDOR_OUI) && (etype == VENDOR_TYPE);
   endfunction

   // updates the ring on a stored frame, searches it newest first on lookup
   function automatic table_reply_t table_reply();
      table_reply_t r;
      int           slot;
      r.accepted = 1'b0;
      r.hit      = 1'b0;
      r.rssi     = '0;
      if (req_op == OP_OBSERVE) begin
         if (vendor_frame_ok(req_frame_len, req_category_code, req_header_org,
                             req_element_id, req_element_org, req_element_type)) begin
            ring_mac[next_slot]  = req_src_mac;
            ring_rssi[next_slot] = req_signal_dbm;
            next_slot = (next_slot + 1) % RING_SLOTS;
            if (held < RING_SLOTS) held = held + 1;
            r.accepted = 1'b1;
         end
      end else begin
         for (int k = 0; k < held; k++) begin
            slot = (next_slot + RING_SLOTS - 1 - k) % RING_SLOTS;
            if (!r.hit && ring_mac[slot] == req_query_mac) begin
               r.hit  = 1'b1;
               r.rssi = ring_rssi[slot];
            end
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin : watch
      table_reply_t want;
      if (reset) begin
         next_slot   = 0;
         held        = 0;
         reply_count = 0;
         reply_queue.delete();
      end else begin
         // a response never belongs to a request taken at the same edge
         if (rsp_valid && rsp_ready) begin
            if (reply_queue.size() == 0) begin
               if (failures < 10)
                  $display("response %0d with nothing expected", reply_count);
               failures = failures + 1;
            end else begin
               want = reply_queue.pop_front();
               if (want.accepted !== rsp_accepted || want.hit !== rsp_hit
                   || want.rssi !== rsp_rssi_out) begin
                  if (failures < 10)
                     $display("response %0d: accepted %0b/%0b hit %0b/%0b rssi %0d/%0d",
                              reply_count, want.accepted, rsp_accepted, want.hit,
                              rsp_hit, want.rssi, rsp_rssi_out);
                  failures = failures + 1;
               end
            end
            reply_count = reply_count + 1;
         end
         if (req_valid && req_ready)
            reply_queue.push_back(table_reply());
      end
      outstanding = reply_queue.size();
   end

endmodule

// ----- dv/frame_filter_rssi_table_top_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// frame_filter_rssi_table_top_test
// drives vendor frames, broken frames and address lookups into the filter
// and strength ring under random idling and a long response hold-off
// ----------------------------------------------------------------------------
module frame_filter_rssi_table_top_test;
   import ffrt_pkg::*;

   localparam int MIN_LEN      = MIN_FRAME_LEN_DEF;
   localparam int POOL_SIZE    = 24;     // more addresses than ring slots, so some age out
   localparam int HOLD_CYCLES  = 120;    // long response hold-off
   localparam int DRAIN_CYCLES = 40;     // beyond the longest lookup search
   localparam int CYCLE_LIMIT  = 400000;

   typedef struct {
      logic                     op;
      logic [LEN_W-1:0]         frame_len;
      logic [BYTE_W-1:0]        category_code;
      logic [ORG_W-1:0]         header_org;
      logic [BYTE_W-1:0]        element_id;
      logic [ORG_W-1:0]         element_org;
      logic [BYTE_W-1:0]        element_type;
      logic [MAC_W-1:0]         src_mac;
      logic signed [RSSI_W-1:0] signal_dbm;
      logic [MAC_W-1:0]         query_mac;
   } frame_req_t;

   logic                     clock;
   logic                     reset             = 1'b1;
   logic                     req_valid         = 1'b0;
   logic                     req_ready;
   logic                     req_op            = OP_OBSERVE;
   logic [LEN_W-1:0]         req_frame_len     = '0;
   logic [BYTE_W-1:0]        req_category_code = '0;
   logic [ORG_W-1:0]         req_header_org    = '0;
   logic [BYTE_W-1:0]        req_element_id    = '0;
   logic [ORG_W-1:0]         req_element_org   = '0;
   logic [BYTE_W-1:0]        req_element_type  = '0;
   logic [MAC_W-1:0]         req_src_mac       = '0;
   logic signed [RSSI_W-1:0] req_signal_dbm    = '0;
   logic [MAC_W-1:0]         req_query_mac     = '0;
   logic                     rsp_valid;
   logic                     rsp_ready         = 1'b0;
   logic                     rsp_accepted;
   logic                     rsp_hit;
   logic signed [RSSI_W-1:0] rsp_rssi_out;

   int                       failures;
   int                       outstanding;
   int                       cycle_count;
   int                       send_idle_pct = 17;
   int                       recv_idle_pct = 55;
   bit                       hold_request  = 1'b0;
   logic [MAC_W-1:0]         mac_pool [POOL_SIZE];

   frame_filter_rssi_table_top i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_op            (req_op),
      .req_frame_len     (req_frame_len),
      .req_category_code (req_category_code),
      .req_header_org    (req_header_org),
      .req_element_id    (req_element_id),
      .req_element_org   (req_element_org),
      .req_element_type  (req_element_type),
      .req_src_mac       (req_src_mac),
      .req_signal_dbm    (req_signal_dbm),
      .req_query_mac     (req_query_mac),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_accepted      (rsp_accepted),
      .rsp_hit           (rsp_hit),
      .rsp_rssi_out      (rsp_rssi_out)
   );

   frame_filter_rssi_table_check i_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_op            (req_op),
      .req_frame_len     (req_frame_len),
      .req_category_code (req_category_code),
      .req_header_org    (req_header_org),
      .req_element_id    (req_element_id),
      .req_element_org   (req_element_org),
      .req_element_type  (req_element_type),
      .req_src_mac       (req_src_mac),
      .req_signal_dbm    (req_signal_dbm),
      .req_query_mac     (req_query_mac),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_accepted      (rsp_accepted),
      .rsp_hit           (rsp_hit),
      .rsp_rssi_out      (rsp_rssi_out),
      .failures          (failures),
      .outstanding       (outstanding)
   );

   // 10 ns clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // item builders
   // ------------------------------------------------------------------------

   function automatic logic [MAC_W-1:0] random_mac();
      logic [63:0] bits;
      bits = {$urandom, $urandom};
      return bits[MAC_W-1:0];
   endfunction

   function automatic logic [MAC_W-1:0] pool_mac();
      return mac_pool[$urandom_range(POOL_SIZE-1, 0)];
   endfunction

   // every field random over its full width, so each bit sees both values
   function automatic frame_req_t noise_req();
      frame_req_t r;
      r.op            = 1'($urandom);
      r.frame_len     = LEN_W'($urandom);
      r.category_code = BYTE_W'($urandom);
      r.header_org    = ORG_W'($urandom);
      r.element_id    = BYTE_W'($urandom);
      r.element_org   = ORG_W'($urandom);
      r.element_type  = BYTE_W'($urandom);
      r.src_mac       = random_mac();
      r.signal_dbm    = RSSI_W'($urandom);
      r.query_mac     = random_mac();
      return r;
   endfunction

   // frame carrying the full vendor signature; query_mac left as noise
   function automatic frame_req_t vendor_frame(logic [MAC_W-1:0] mac,
                                               logic signed [RSSI_W-1:0] dbm);
      frame_req_t r;
      r               = noise_req();
      r.op            = OP_OBSERVE;
      r.frame_len     = LEN_W'($urandom_range((1 << LEN_W) - 1, MIN_LEN));
      r.category_code = CAT_VENDOR;
      r.header_org    = VENDOR_OUI;
      r.element_id    = ELEM_VENDOR;
      r.element_org   = VENDOR_OUI;
      r.element_type  = VENDOR_TYPE;
      r.src_mac       = mac;
      r.signal_dbm    = dbm;
      return r;
   endfunction

   // vendor frame with exactly one filter condition broken
   function automatic frame_req_t broken_frame(logic [MAC_W-1:0] mac,
                                               logic signed [RSSI_W-1:0] dbm,
                                               int which);
      frame_req_t  r;
      int unsigned bit_pos;
      r       = vendor_frame(mac, dbm);
      bit_pos = $urandom_range(ORG_W-1, 0);
      case (which)
         0: r.frame_len = LEN_W'($urandom_range(MIN_LEN-1, 0));
         1: r.category_code[bit_pos % BYTE_W] = ~r.category_code[bit_pos % BYTE_W];
         2: r.header_org[bit_pos] = ~r.header_org[bit_pos];
         3: r.element_id[bit_pos % BYTE_W] = ~r.element_id[bit_pos % BYTE_W];
         4: r.element_org[bit_pos] = ~r.element_org[bit_pos];
         default: r.element_type[bit_pos % BYTE_W] = ~r.element_type[bit_pos % BYTE_W];
      endcase
      return r;
   endfunction

   function automatic frame_req_t lookup_req(logic [MAC_W-1:0] mac);
      frame_req_t r;
      r           = noise_req();
      r.op        = OP_LOOKUP;
      r.query_mac = mac;
      return r;
   endfunction

   // mostly well formed traffic on a small address pool, so lookups hit
   function automatic frame_req_t random_req();
      int unsigned pick;
      pick = $urandom_range(99, 0);
      if (pick < 45)
         return vendor_frame(pool_mac(), RSSI_W'($urandom));
      else if (pick < 55)
         return broken_frame(pool_mac(), RSSI_W'($urandom), $urandom_range(5, 0));
      else if (pick < 85)
         return lookup_req(pool_mac());
      else if (pick < 90)
         return lookup_req(random_mac());
      else
         return noise_req();
   endfunction

   // ------------------------------------------------------------------------
   // request side: optional idle gap, then hold valid until the transfer
   // ------------------------------------------------------------------------
   task automatic offer_request(input frame_req_t r);
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_op            <= r.op;
      req_frame_len     <= r.frame_len;
      req_category_code <= r.category_code;
      req_header_org    <= r.header_org;
      req_element_id    <= r.element_id;
      req_element_org   <= r.element_org;
      req_element_type  <= r.element_type;
      req_src_mac       <= r.src_mac;
      req_signal_dbm    <= r.signal_dbm;
      req_query_mac     <= r.query_mac;
      @(posedge clock);
      // values read right after the edge are the ones the edge sampled
      while (!req_ready) @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // response side: random stalls, or a long hold-off when asked for
   // ------------------------------------------------------------------------
   initial begin : result_sink
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_ready <= 1'b0;
            // requests keep coming while this lasts, so the command queue fills
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
            @(posedge clock);
         end
      end
   end

   // run limit
   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count = cycle_count + 1;
      end
      $display("frame_filter_rssi_table_top test failed");
      $finish;
   end

   // ------------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------------
   initial begin : stimulus
      frame_req_t r;
      // address pool with both extremes
      mac_pool[0] = '0;
      mac_pool[1] = '1;
      for (int i = 2; i < POOL_SIZE; i++)
         mac_pool[i] = random_mac();

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed part ---
      // lookup on an empty ring
      offer_request(lookup_req(mac_pool[0]));
      // shortest frame, zero address, weakest signal
      r = vendor_frame(mac_pool[0], -8'sd128);
      r.frame_len = LEN_W'(MIN_LEN);
      offer_request(r);
      // longest frame, all-ones address, strongest signal
      r = vendor_frame(mac_pool[1], 8'sd127);
      r.frame_len = '1;
      offer_request(r);
      // same address again, newer entry must win on lookup
      offer_request(vendor_frame(mac_pool[1], 8'sd0));
      // one rejected frame per filter condition, length just below the minimum
      r = broken_frame(random_mac(), RSSI_W'($urandom), 0);
      r.frame_len = LEN_W'(MIN_LEN - 1);
      offer_request(r);
      for (int w = 1; w < 6; w++)
         offer_request(broken_frame(random_mac(), RSSI_W'($urandom), w));
      // duplicate hit with strength zero, then a plain miss
      offer_request(lookup_req(mac_pool[1]));
      offer_request(lookup_req(random_mac()));
      // fill the ring to exactly sixteen entries
      for (int i = 2; i < 15; i++)
         offer_request(vendor_frame(mac_pool[i], RSSI_W'($urandom)));
      // oldest held entry must still be found
      offer_request(lookup_req(mac_pool[0]));
      // one more frame wraps the ring and evicts it
      offer_request(vendor_frame(mac_pool[15], RSSI_W'($urandom)));
      offer_request(lookup_req(mac_pool[0]));

      // --- random part, phase one: sender idles lightly, receiver heavily ---
      for (int i = 0; i < 600; i++)
         offer_request(random_req());

      // phase two: roles swapped, opened by a long response hold-off
      send_idle_pct = 55;
      recv_idle_pct = 17;
      hold_request  = 1'b1;
      for (int i = 0; i < 600; i++)
         offer_request(random_req());

      // phase three: no idling on either side, again after a hold-off
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_request  = 1'b1;
      for (int i = 0; i < 500; i++)
         offer_request(random_req());
      req_valid <= 1'b0;

      // drain: every expected response in, then a margin for stray ones
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (failures == 0 && outstanding == 0)
         $display("frame_filter_rssi_table_top test passed");
      else
         $display("frame_filter_rssi_table_top test failed");
      $finish;
   end

endmodule
